// ===== hw/rtl/counting_semaphore_with_wait_queue_defines.svh =====
// Assertion macros for the semaphore block.
`ifndef COUNTING_SEMAPHORE_WITH_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WITH_WAIT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("semaphore assertion failed");
`define CSEM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("semaphore reset assertion failed");
`else
`define CSEM_ASSERT(lbl, prop)
`define CSEM_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== hw/rtl/csem_pkg.sv =====
`timescale 1ns / 1ps
package csem_pkg;

  localparam int unsigned COUNT_W = 9;
  localparam int unsigned INIT_W  = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 9'sd255;
  localparam logic signed [COUNT_W-1:0] COUNT_RESET = 9'sd1;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_WOKE     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_FULL     = 3'd4,
    ST_ANOMALY  = 3'd5
  } status_e;

  typedef enum logic {
    ACT_WAIT   = 1'b0,
    ACT_SIGNAL = 1'b1
  } action_e;

  typedef struct packed {
    status_e                    status;
    logic signed [COUNT_W-1:0]  count;
    logic                       pop;
  } resp_t;

endpackage

// ===== hw/rtl/csem_ram.sv =====
`timescale 1ns / 1ps
module csem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/csem_ctrl.sv =====
`timescale 1ns / 1ps
module csem_ctrl
  import csem_pkg::*;
#(
  parameter int unsigned MAX_WAITERS    = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [INIT_W-1:0]              cfg_wdata_i,
  input  logic                           req_vld_i,
  input  action_e                        action_i,
  input  logic [THREAD_ID_BITS-1:0]      tid_i,
  input  logic                           resp_take_i,
  output logic                           resp_vld_o,
  output resp_t                          resp_o,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_WAITERS)-1:0] ram_waddr_o,
  output logic [THREAD_ID_BITS-1:0]      ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(MAX_WAITERS)-1:0] ram_raddr_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WAITERS);
  localparam int unsigned OCC_W = $clog2(MAX_WAITERS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WAITERS - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(MAX_WAITERS);

  logic signed [COUNT_W-1:0] count_q, count_d, count_inc, count_dec;
  logic [PTR_W-1:0]          head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic                      resp_vld_q, resp_vld_d;
  resp_t                     resp_q, resp_d;
  logic                      push, pop;

  assign count_inc = count_q + 9'sd1;
  assign count_dec = count_q - 9'sd1;

  always_comb begin
    count_d    = count_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    resp_d     = resp_q;
    resp_vld_d = resp_vld_q && !resp_take_i;
    push       = 1'b0;
    pop        = 1'b0;

    if (cfg_we_i) begin
      if (cfg_wdata_i != '0) begin
        count_d = COUNT_W'($signed({1'b0, cfg_wdata_i}));
        head_d  = '0;
        tail_d  = '0;
        occ_d   = '0;
      end
    end else if (req_vld_i) begin
      resp_vld_d   = 1'b1;
      resp_d.pop   = 1'b0;
      if (action_i == ACT_WAIT) begin
        if (count_q > 9'sd0) begin
          count_d       = count_dec;
          resp_d.status = ST_GRANTED;
        end else if (occ_q == OCC_FULL) begin
          resp_d.status = ST_FULL;
        end else begin
          push          = 1'b1;
          count_d       = count_dec;
          tail_d        = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
          occ_d         = occ_q + 1'b1;
          resp_d.status = ST_QUEUED;
        end
      end else begin
        if (count_q >= COUNT_MAX) begin
          resp_d.status = ST_ANOMALY;
        end else begin
          count_d = count_inc;
          if (count_inc > 9'sd0) begin
            resp_d.status = ST_RELEASED;
          end else if (occ_q == '0) begin
            resp_d.status = ST_ANOMALY;
          end else begin
            pop           = 1'b1;
            head_d        = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
            occ_d         = occ_q - 1'b1;
            resp_d.status = ST_WOKE;
            resp_d.pop    = 1'b1;
          end
        end
      end
      resp_d.count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= COUNT_RESET;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      resp_vld_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      resp_vld_q <= resp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    resp_q <= resp_d;
  end

  assign resp_vld_o  = resp_vld_q;
  assign resp_o      = resp_q;
  assign ram_we_o    = push;
  assign ram_waddr_o = tail_q;
  assign ram_wdata_o = tid_i;
  assign ram_re_o    = pop;
  assign ram_raddr_o = head_q;

endmodule

// ===== hw/rtl/counting_semaphore_with_wait_queue.sv =====
`timescale 1ns / 1ps
// Channel   Group    Beat contents
// request   s_axis   tuser: action; tdata: thread_id
// result    m_axis   tuser: status; tdata: woken_thread, current_count
// config    cfg      cfg_wdata_i: initial_count, taken when cfg_we_i is high and it is nonzero
//
// One request is accepted per cycle while the output path drains; its result is
// held in the response stage, alongside the waiter RAM read, then in the m_axis output register.
// The count, queue pointers and occupancy update in the accept cycle.
// Reset restores a count of one and an empty queue; no clearing pass runs.
// A stalled result holds the response stage, which then blocks new requests.
`include "counting_semaphore_with_wait_queue_defines.svh"
module counting_semaphore_with_wait_queue
  import csem_pkg::*;
#(
  parameter int unsigned MAX_WAITERS    = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [INIT_W-1:0]        cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [THREAD_ID_BITS-1:0] thread_id
  input  logic [((THREAD_ID_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // [0] action
  input  logic                     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [THREAD_ID_BITS-1:0] woken_thread, then current_count (9 bits)
  output logic [((THREAD_ID_BITS+COUNT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]               m_axis_tuser_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WAITERS);
  localparam int unsigned OUT_W = ((THREAD_ID_BITS + COUNT_W + 7) / 8) * 8;

  logic                      in_fire, out_free, resp_vld, resp_take;
  resp_t                     resp;
  logic                      ram_we, ram_re;
  logic [PTR_W-1:0]          ram_waddr, ram_raddr;
  logic [THREAD_ID_BITS-1:0] ram_wdata, ram_rdata;

  logic                      out_vld_q, out_vld_d;
  status_e                   out_status_q;
  logic [THREAD_ID_BITS-1:0] out_woken_q;
  logic signed [COUNT_W-1:0] out_count_q;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign resp_take       = resp_vld && out_free;
  assign s_axis_tready_o = !resp_vld || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  csem_ctrl #(
    .MAX_WAITERS   (MAX_WAITERS),
    .THREAD_ID_BITS(THREAD_ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_vld_i   (in_fire),
    .action_i    (action_e'(s_axis_tuser_i)),
    .tid_i       (s_axis_tdata_i[THREAD_ID_BITS-1:0]),
    .resp_take_i (resp_take),
    .resp_vld_o  (resp_vld),
    .resp_o      (resp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  csem_ram #(
    .WIDTH(THREAD_ID_BITS),
    .DEPTH(MAX_WAITERS)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_vld_d = resp_take || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_take) begin
      out_status_q <= resp.status;
      out_woken_q  <= resp.pop ? ram_rdata : '0;
      out_count_q  <= resp.count;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_W'({out_count_q, out_woken_q});

  `CSEM_ASSERT(a_queued_negative, (out_vld_q && out_status_q == ST_QUEUED) |-> out_count_q[COUNT_W-1])
  `CSEM_ASSERT(a_granted_nonneg, (out_vld_q && out_status_q == ST_GRANTED) |-> !out_count_q[COUNT_W-1])
  `CSEM_ASSERT(a_woke_nonpos, (out_vld_q && out_status_q == ST_WOKE) |-> (out_count_q <= 9'sd0))
  `CSEM_ASSERT(a_take_moves, resp_take |=> out_vld_q)
  `CSEM_ASSERT_RST(a_reset_empty, !rst_ni |=> (!out_vld_q && !resp_vld))

endmodule

// ===== test/counting_semaphore_with_wait_queue_test.sv =====
`timescale 1ns / 1ps
module counting_semaphore_with_wait_queue_test;
  import csem_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned HOLD_LEN = 80;
  localparam int unsigned IDLE_MAX = 2000;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned PHASE_N  = 115;

  typedef struct packed {
    action_e          act;
    logic [TID_W-1:0] tid;
  } request_t;

  typedef struct packed {
    status_e                   status;
    logic [TID_W-1:0]          woken;
    logic signed [COUNT_W-1:0] count;
  } reply_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [INIT_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [TID_W-1:0]     s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [23:0]          m_axis_tdata_o;
  logic [2:0]           m_axis_tuser_o;

  counting_semaphore_with_wait_queue #(
    .MAX_WAITERS   (DEPTH),
    .THREAD_ID_BITS(TID_W)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Semaphore state as seen by the checker
  int                 sem_count;
  logic [TID_W-1:0]   waiter_ring [DEPTH];
  int                 ring_head;
  int                 ring_tail;
  int                 waiters_held;

  request_t           request_q [$];
  reply_t             due_replies [$];
  request_t           nxt;
  reply_t             want;
  reply_t             got;

  int unsigned        send_idle_pct;
  int unsigned        rx_stall_pct;
  bit                 hold_request;
  int unsigned        hold_left;
  bit                 req_taken;
  bit                 res_taken;
  int unsigned        idle_cycles;
  int unsigned        fails;

  int                 phase_init [N_PHASES] = '{1, 255, 4, 128, 1, 250, 16, 2};
  int unsigned        phase_tx   [N_PHASES] = '{0, 0, 74, 74, 0, 0, 35, 35};
  int unsigned        phase_rx   [N_PHASES] = '{0, 0, 0, 0, 74, 74, 35, 35};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void load_initial_count(logic [INIT_W-1:0] v);
    if (v == '0) return;
    sem_count    = int'(v);
    ring_head    = 0;
    ring_tail    = 0;
    waiters_held = 0;
  endfunction

  function automatic reply_t apply_request(action_e act, logic [TID_W-1:0] tid);
    reply_t r;
    r.woken = '0;
    if (act == ACT_WAIT) begin
      if (sem_count >= 1) begin
        sem_count--;
        r.status = ST_GRANTED;
      end else if (waiters_held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        sem_count--;
        waiter_ring[ring_tail] = tid;
        ring_tail = (ring_tail + 1) % DEPTH;
        waiters_held++;
        r.status = ST_QUEUED;
      end
    end else begin
      if (sem_count >= int'(COUNT_MAX)) begin
        r.status = ST_ANOMALY;
      end else begin
        sem_count++;
        if (sem_count > 0) begin
          r.status = ST_RELEASED;
        end else if (waiters_held == 0) begin
          r.status = ST_ANOMALY;
        end else begin
          r.woken = waiter_ring[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          waiters_held--;
          r.status = ST_WOKE;
        end
      end
    end
    r.count = COUNT_W'(sem_count);
    return r;
  endfunction

  task automatic push_req(action_e act, logic [TID_W-1:0] tid);
    request_t item;
    item.act = act;
    item.tid = tid;
    request_q.push_back(item);
  endtask

  // Wait for all requests and due replies to drain, sampling at the rising edge, where the driver outputs are stable
  task automatic settle();
    @(posedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid_i || due_replies.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_init(logic [INIT_W-1:0] v);
    settle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    load_initial_count(v);
  endtask

  // Mostly take/release bursts, deep enough to fill the wait queue for small initial counts, some noise
  task automatic fill_random(int n, int init_v);
    int left;
    int k;
    int cap;
    int roll;
    left = n;
    cap  = (init_v + 18 > 40) ? 40 : init_v + 18;
    while (left > 0) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        k = $urandom_range(cap, 1);
        for (int i = 0; i < k; i++) push_req(ACT_WAIT, TID_W'($urandom_range(255)));
        for (int i = 0; i < k; i++) push_req(ACT_SIGNAL, TID_W'($urandom_range(255)));
        left -= 2 * k;
      end else if (roll < 85) begin
        k = $urandom_range(8, 1);
        for (int i = 0; i < k; i++) push_req(ACT_SIGNAL, TID_W'($urandom_range(255)));
        for (int i = 0; i < k; i++) push_req(ACT_WAIT, TID_W'($urandom_range(255)));
        left -= 2 * k;
      end else begin
        push_req(($urandom_range(99) < 60) ? ACT_WAIT : ACT_SIGNAL,
                 TID_W'($urandom_range(255)));
        left--;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || req_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= nxt.act;
        s_axis_tdata_i  <= nxt.tid;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_LEN;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    req_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    res_taken = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (req_taken) begin
      due_replies.push_back(apply_request(action_e'(s_axis_tuser_i), s_axis_tdata_i));
    end
    if (res_taken) begin
      got.status = status_e'(m_axis_tuser_o);
      got.woken  = m_axis_tdata_o[TID_W-1:0];
      got.count  = m_axis_tdata_o[TID_W +: COUNT_W];
      if (due_replies.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("result beat with nothing due: status %0d woken %0h count %0d",
                   got.status, got.woken, got.count);
      end else begin
        want = due_replies.pop_front();
        if (got.status != want.status || got.woken != want.woken ||
            got.count != want.count) begin
          fails++;
          if (fails <= 10)
            $display("beat mismatch: status %0d/%0d woken %0h/%0h count %0d/%0d (exp/got)",
                     want.status, got.status, want.woken, got.woken,
                     want.count, got.count);
        end
      end
    end
    if (req_taken || res_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    send_idle_pct   = 0;
    rx_stall_pct    = 0;
    hold_request    = 1'b0;
    hold_left       = 0;
    idle_cycles     = 0;
    fails           = 0;
    sem_count       = int'(COUNT_RESET);
    ring_head       = 0;
    ring_tail       = 0;
    waiters_held    = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // grant, queue, wake, release from the reset count of one
    push_req(ACT_WAIT, 8'h00);
    push_req(ACT_WAIT, 8'hFF);
    push_req(ACT_SIGNAL, 8'h00);
    push_req(ACT_SIGNAL, 8'hFF);
    // zero write must leave count at one
    write_init(8'd0);
    push_req(ACT_WAIT, 8'hA5);
    // signal at the top of the count is refused
    write_init(8'd255);
    push_req(ACT_SIGNAL, 8'h5A);
    push_req(ACT_WAIT, 8'h5A);
    // fill the wait queue, then one wait too many
    write_init(8'd1);
    push_req(ACT_WAIT, 8'h3C);
    for (int i = 0; i < DEPTH; i++) push_req(ACT_WAIT, TID_W'($urandom_range(255)));
    push_req(ACT_WAIT, 8'hC3);
    push_req(ACT_SIGNAL, 8'h00);

    for (int p = 0; p < N_PHASES; p++) begin
      write_init(INIT_W'(phase_init[p]));
      send_idle_pct = phase_tx[p];
      rx_stall_pct  = phase_rx[p];
      fill_random(PHASE_N, phase_init[p]);
      if (p == 0) hold_request = 1'b1;
    end

    settle();
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
